FILE: rtl/bir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_pkg
// Shared widths and polynomial coefficient tables (Q30) for the I1/I0 ratio.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int QUO_W = 31;   // quotient bits of both dividers
  localparam int ACC_W = 36;   // signed Horner accumulator
  localparam int M_W   = 31;   // Horner multiplier operand r or s
  localparam int X_W   = 24;

  typedef logic signed [ACC_W-1:0] acc_t;

  // round-to-nearest Q30 of an eight-decimal coefficient
  function automatic acc_t qc(input longint n);
    longint t;
    begin
      t = (n * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
      return t[ACC_W-1:0];
    end
  endfunction

  localparam acc_t I0_BIG [9] = '{
    qc(39894228), qc(1328592), qc(225319), -qc(157565), qc(916281),
    -qc(2057706), qc(2635537), -qc(1647633), qc(392377)
  };
  localparam acc_t I1_BIG [9] = '{
    qc(39894228), -qc(3988024), -qc(362018), qc(163801), -qc(1031555),
    qc(2282967), -qc(2895312), qc(1787654), -qc(420059)
  };
  // small-argument fits padded with two leading zero terms to eight steps
  localparam acc_t I0_SMALL [9] = '{
    qc(100000000), qc(351562290), qc(308994240), qc(120674920),
    qc(26597320), qc(3607680), qc(458130), qc(0), qc(0)
  };
  localparam acc_t I1_SMALL [9] = '{
    qc(50000000), qc(87890594), qc(51498869), qc(15084934),
    qc(2658733), qc(301532), qc(32411), qc(0), qc(0)
  };

endpackage

FILE: rtl/bessel_i1_over_i0_ratio.sv
`timescale 1ns / 1ps
// throughput: one argument per cycle unless the output stalls; two 31-stage
//   bit-per-cycle dividers and eight Horner stages are fully pipelined, so
//   nothing recirculates
// a stalled output freezes the whole pipeline in place
// reset clears only the valid bits; no data state survives between items
// ----------------------------------------------------------------------------
// bessel_i1_over_i0_ratio
// Streaming fixed-point evaluator of I1(x)/I0(x) from polynomial fits.
// ----------------------------------------------------------------------------
module bessel_i1_over_i0_ratio #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] x_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] ratio_o
);
  import bir_pkg::*;

  localparam int F = IN_FRAC_BITS;
  localparam int G = OUT_FRAC_BITS;
  localparam logic [27:0] BRANCH_LIM = 28'(64'd15 << F);
  localparam logic [63:0] UP_NUM     = 64'd15 << (F + 30);
  localparam int          LOW_SH     = 32 - F;
  localparam int          OUT_SH     = F + 30 - G;
  localparam logic [15:0] LIMIT      = (G >= 16) ? 16'hFFFF : 16'((64'd1 << G) - 64'd1);

  logic en;
  logic out_valid_q;
  logic [15:0] ratio_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // input register
  logic           s0_v_q;
  logic [X_W-1:0] s0_x_q;
  logic           s0_up;
  logic [63:0]    a_num;
  logic [25:0]    a_den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_x_q <= x_value_i;
    end
  end

  // upper fit divides 15*2^(F+30) by 4x, lower fit divides x*2^(32-F) by 15
  assign s0_up = {2'b00, s0_x_q, 2'b00} > BRANCH_LIM;
  assign a_num = s0_up ? UP_NUM : (64'(s0_x_q) << LOW_SH);
  assign a_den = s0_up ? {s0_x_q, 2'b00} : 26'd15;

  logic             a_v;
  logic [QUO_W-1:0] a_q;
  logic [X_W:0]     a_tag;

  bir_div #(.NW(64), .DW(26), .TW(X_W + 1)) u_div_arg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s0_v_q),
    .num_i  (a_num),
    .den_i  (a_den),
    .tag_i  ({s0_x_q, s0_up}),
    .valid_o(a_v),
    .quo_o  (a_q),
    .tag_o  (a_tag)
  );

  // Horner chain: index 0 holds the multiplier and start values
  logic [8:0]     h_v_q;
  logic [8:0]     h_up_q;
  acc_t           h_accv_q [9];
  acc_t           h_accw_q [9];
  logic [M_W-1:0] h_m_q    [9];
  logic [X_W-1:0] h_x_q    [9];
  acc_t           hn_accv  [9];
  acc_t           hn_accw  [9];
  logic [M_W-1:0] hn_m;
  logic [61:0]    sq_prod;

  assign sq_prod = a_q * a_q;
  assign hn_m    = a_tag[0] ? {1'b0, a_q[29:0]} : sq_prod[60:30];
  assign hn_accv[0] = a_tag[0] ? I0_BIG[8] : I0_SMALL[8];
  assign hn_accw[0] = a_tag[0] ? I1_BIG[8] : I1_SMALL[8];

  for (genvar j = 1; j < 9; j++) begin : g_horner
    logic signed [67:0] pv;
    logic signed [67:0] pw;
    acc_t               cv;
    acc_t               cw;
    assign pv = h_accv_q[j-1] * $signed({1'b0, h_m_q[j-1]});
    assign pw = h_accw_q[j-1] * $signed({1'b0, h_m_q[j-1]});
    assign cv = h_up_q[j-1] ? I0_BIG[8-j] : I0_SMALL[8-j];
    assign cw = h_up_q[j-1] ? I1_BIG[8-j] : I1_SMALL[8-j];
    // arithmetic shift gives the floor for negative products
    assign hn_accv[j] = acc_t'(pv >>> 30) + cv;
    assign hn_accw[j] = acc_t'(pw >>> 30) + cw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= '0;
    end else if (en) begin
      h_v_q <= {h_v_q[7:0], a_v};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_m_q[0]  <= hn_m;
      h_x_q[0]  <= a_tag[X_W:1];
      h_up_q[0] <= a_tag[0];
      for (int j = 0; j < 9; j++) begin
        h_accv_q[j] <= hn_accv[j];
        h_accw_q[j] <= hn_accw[j];
      end
      for (int j = 1; j < 9; j++) begin
        h_m_q[j]  <= h_m_q[j-1];
        h_x_q[j]  <= h_x_q[j-1];
        h_up_q[j] <= h_up_q[j-1];
      end
    end
  end

  // classify and set up the final division
  acc_t        w;
  acc_t        v;
  logic        wpos;
  logic        vpos;
  logic [63:0] c_num;
  logic [33:0] c_den;
  logic        c_ovf;

  assign w    = h_accw_q[8];
  assign v    = h_accv_q[8];
  assign wpos = !w[ACC_W-1] && (w != '0);
  assign vpos = !v[ACC_W-1] && (v != '0);

  always_comb begin
    if (!h_up_q[8]) begin
      c_num = 64'(w[34:0]) << 30;
      c_den = v[33:0];
    end else if (wpos && vpos) begin
      c_num = 64'(w[34:0]) << G;
      c_den = v[33:0];
    end else begin
      c_num = '0;
      c_den = 34'd1;
    end
    c_ovf = (c_num >> QUO_W) >= 64'(c_den);
  end

  logic           c_v_q;
  logic [63:0]    c_num_q;
  logic [33:0]    c_den_q;
  logic [X_W-1:0] c_x_q;
  logic [3:0]     c_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= h_v_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_num_q   <= c_num;
      c_den_q   <= c_den;
      c_x_q     <= h_x_q[8];
      c_flags_q <= {h_up_q[8], wpos, vpos, c_ovf};
    end
  end

  logic             b_v;
  logic [QUO_W-1:0] b_q;
  logic [X_W+3:0]   b_tag;

  bir_div #(.NW(64), .DW(34), .TW(X_W + 4)) u_div_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(c_v_q),
    .num_i  (c_num_q),
    .den_i  (c_den_q),
    .tag_i  ({c_x_q, c_flags_q}),
    .valid_o(b_v),
    .quo_o  (b_q),
    .tag_o  (b_tag)
  );

  // scale by x for the lower fit, pick the upper-fit result
  logic [15:0] up_res;

  always_comb begin
    priority if (!b_tag[2]) begin
      up_res = '0;
    end else if (!b_tag[1] || b_tag[0]) begin
      up_res = LIMIT;
    end else if (b_q > 31'(LIMIT)) begin
      up_res = LIMIT;
    end else begin
      up_res = b_q[15:0];
    end
  end

  logic        m_v_q;
  logic        m_up_q;
  logic [54:0] m_prod_q;
  logic [15:0] m_up_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= b_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_prod_q   <= b_tag[X_W+3:4] * b_q;
      m_up_q     <= b_tag[3];
      m_up_res_q <= up_res;
    end
  end

  logic [54:0] low_sh;
  logic [15:0] res;

  assign low_sh = m_prod_q >> OUT_SH;

  always_comb begin
    if (m_up_q) begin
      res = m_up_res_q;
    end else if (low_sh > 55'(LIMIT)) begin
      res = LIMIT;
    end else begin
      res = low_sh[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ratio_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ratio_o     = ratio_q;

endmodule

FILE: rtl/bir_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module bir_div #(
  parameter int NW = 64,
  parameter int DW = 26,
  parameter int TW = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [NW-1:0]             num_i,
  input  logic [DW-1:0]             den_i,
  input  logic [TW-1:0]             tag_i,
  output logic                      valid_o,
  output logic [bir_pkg::QUO_W-1:0] quo_o,
  output logic [TW-1:0]             tag_o
);
  import bir_pkg::*;

  logic [QUO_W-1:0] vld_q;
  logic [DW-1:0]    rem_q [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [DW-1:0]    den_q [QUO_W];
  logic [TW-1:0]    tag_q [QUO_W];

  logic [DW-1:0]    rem_d [QUO_W];
  logic [QUO_W-1:0] lo_d  [QUO_W];
  logic [DW-1:0]    den_d [QUO_W];
  logic [TW-1:0]    tag_d [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [DW-1:0]    rem_in;
    logic [QUO_W-1:0] lo_in;
    logic [DW-1:0]    den_in;
    logic [TW-1:0]    tag_in;
    logic [DW+1:0]    trial;

    if (i == 0) begin : g_first
      assign rem_in = DW'(num_i >> QUO_W);
      assign lo_in  = num_i[QUO_W-1:0];
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign den_in = den_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    assign trial = {1'b0, rem_in, lo_in[QUO_W-1]} - {2'b00, den_in};

    always_comb begin
      if (trial[DW+1]) begin
        rem_d[i] = {rem_in[DW-2:0], lo_in[QUO_W-1]};
        lo_d[i]  = {lo_in[QUO_W-2:0], 1'b0};
      end else begin
        rem_d[i] = trial[DW-1:0];
        lo_d[i]  = {lo_in[QUO_W-2:0], 1'b1};
      end
      den_d[i] = den_in;
      tag_d[i] = tag_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QUO_W; i++) begin
        rem_q[i] <= rem_d[i];
        lo_q[i]  <= lo_d[i];
        den_q[i] <= den_d[i];
        tag_q[i] <= tag_d[i];
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = lo_q[QUO_W-1];
  assign tag_o   = tag_q[QUO_W-1];

endmodule
